// File: design/txo_pkg.sv
// Shared types and constants of the 3x3 text outline filter.
// Used by txo_position, txo_window and text_outline_3x3_core; depends on nothing.
package txo_pkg;

   localparam int DEF_MAX_WIDTH = 1024;

   localparam int PIX_W        = 8;
   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 13;
   localparam int ROW_W        = 13;
   localparam int EMIT_W       = 22;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [ROW_W-1:0]        ROW_MAX    = '1;
   localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_MIN = 13'd1;
   localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_MAX = 13'd4096;
   localparam int                      WIDTH_MIN  = 3;

   localparam logic [CFG_WIDTH_W-1:0]  RST_WIDTH  = 11'd320;
   localparam logic [CFG_HEIGHT_W-1:0] RST_HEIGHT = 13'd200;

   localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;
   localparam logic [PIX_W-1:0] PIX_ZERO  = 8'h00;

   // Register index, taken from bit 2 of the byte address.
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   // Per-item position decisions, made when the item is accepted.
   typedef struct packed {
      logic in_rows;   // current row lies inside the frame
      logic top_en;    // row two above lies inside the frame
      logic mid_en;    // row one above lies inside the frame
      logic col0;      // item sits in the first column
      logic emit;      // item produces a result
      logic last;      // that result is the final pixel of the frame
   } pos_type;

endpackage

// File: design/text_outline_3x3_core.sv
// Top level of the 3x3 text outline filter: register port, line buffers and pipeline.
// Depends on txo_pkg, txo_position and txo_window.

// The block takes one palette pixel per clock in raster order and returns the
// outlined frame in the same order: a zero pixel next to a white (255) pixel
// inside the frame becomes 1, every other pixel passes unchanged. A result is
// registered out after the item one row and one pixel later is accepted, so
// after the last pixel of a frame the host sends frame_width+1 flush items; the
// final pixel carries rsp_tlast. Throughput is one item per cycle, set by the
// single read and single write per cycle of the two line buffers (MAX_WIDTH
// entries each); ready is only held low while the output register is full and
// not taken, and in the cycle after a register write while the frame size
// product is updated. The host must write registers only between transactions,
// which the block does not check; frame_width is at address 0, frame_height at 4.
module text_outline_3x3_core #(
   parameter int MAX_WIDTH = txo_pkg::DEF_MAX_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [txo_pkg::PIX_W-1:0]        req_tdata,   // [7:0] pixel_in
   input  logic                             req_tuser,   // [0] flush

   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [txo_pkg::PIX_W-1:0]        rsp_tdata,   // [7:0] pixel_out
   output logic                             rsp_tlast,   // frame_last

   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [txo_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [txo_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [txo_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import txo_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int IW = $clog2(MAX_WIDTH);
   localparam int PW = CW + CFG_HEIGHT_W;
   localparam int XW = ((CW > CFG_WIDTH_W) ? CW : CFG_WIDTH_W) + 1;

   // Configuration registers.
   logic [CFG_WIDTH_W-1:0]  width_ff;
   logic [CFG_HEIGHT_W-1:0] height_ff;
   logic                    cfg_hold_ff;
   logic [PW-1:0]           pixel_limit_ff;
   logic                    csr_write;
   logic                    csr_reg;

   logic [XW-1:0]           width_x;
   logic [CW-1:0]           eff_width;
   logic [CFG_HEIGHT_W-1:0] eff_height;

   // Pipeline.
   logic        accept;
   logic [IW-1:0] line_idx;
   pos_type     pos;
   logic [PIX_W-1:0] bot_pix;

   logic             s1_valid_ff;
   pos_type          s1_pos_ff;
   logic [IW-1:0]    s1_idx_ff;
   logic [PIX_W-1:0] s1_bot_ff;
   logic [PIX_W-1:0] center_rd_ff;
   logic             flag_rd_ff;
   logic             s1_adv;
   logic             out_free;

   logic             top_white;
   logic [PIX_W-1:0] mid_pix;
   logic             bot_white;
   logic [PIX_W-1:0] result;

   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_data_ff;
   logic             rsp_last_ff;

   // Line buffers: previous row's pixels, and the row above that as white flags.
   logic [PIX_W-1:0] center_mem [MAX_WIDTH];
   logic             flag_mem   [MAX_WIDTH];

   // ---------------------------------------------------------------- registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_reg    = csr_paddr[2];

   always_comb begin
      case (csr_reg)
         REG_FRAME_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= RST_WIDTH;
         height_ff   <= RST_HEIGHT;
         cfg_hold_ff <= 1'b0;
      end else begin
         cfg_hold_ff <= csr_write;
         if (csr_write) begin
            case (csr_reg)
               REG_FRAME_WIDTH:  width_ff  <= csr_pwdata[CFG_WIDTH_W-1:0];
               REG_FRAME_HEIGHT: height_ff <= csr_pwdata[CFG_HEIGHT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      width_x = XW'(width_ff);
      if (width_x < XW'(WIDTH_MIN)) begin
         eff_width = CW'(WIDTH_MIN);
      end else if (width_x > XW'(MAX_WIDTH)) begin
         eff_width = CW'(MAX_WIDTH);
      end else begin
         eff_width = width_x[CW-1:0];
      end

      if (height_ff < HEIGHT_MIN) begin
         eff_height = HEIGHT_MIN;
      end else if (height_ff > HEIGHT_MAX) begin
         eff_height = HEIGHT_MAX;
      end else begin
         eff_height = height_ff;
      end
   end

   // Index of the final pixel of a frame; ready is held low in the cycle after a write.
   always_ff @(posedge clock) begin
      pixel_limit_ff <= PW'(eff_width) * PW'(eff_height) - PW'(1);
   end

   // ----------------------------------------------------------------- position
   txo_position #(
      .MAX_WIDTH (MAX_WIDTH),
      .CW        (CW),
      .IW        (IW),
      .PW        (PW)
   ) u_position (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .eff_width   (eff_width),
      .eff_height  (eff_height),
      .pixel_limit (pixel_limit_ff),
      .line_idx    (line_idx),
      .pos         (pos)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && (!s1_pos_ff.emit || out_free);
   assign req_tready = !cfg_hold_ff && (!s1_valid_ff || s1_adv);
   assign accept     = req_tvalid && req_tready;
   assign bot_pix    = (req_tuser || !pos.in_rows) ? PIX_ZERO : req_tdata;

   // Line buffers are read when an item is accepted and written when it leaves
   // the window stage. Two items that share an entry back to back only occur
   // across a frame end, where the newer item masks what it reads.
   always_ff @(posedge clock) begin
      if (accept) begin
         center_rd_ff <= center_mem[line_idx];
      end
      if (s1_adv) begin
         center_mem[s1_idx_ff] <= s1_bot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         flag_rd_ff <= flag_mem[line_idx];
      end
      if (s1_adv) begin
         flag_mem[s1_idx_ff] <= (mid_pix == PIX_WHITE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pos_ff <= pos;
         s1_idx_ff <= line_idx;
         s1_bot_ff <= bot_pix;
      end
   end

   // ------------------------------------------------------------------- window
   assign top_white = s1_pos_ff.top_en && flag_rd_ff;
   assign mid_pix   = s1_pos_ff.mid_en ? center_rd_ff : PIX_ZERO;
   assign bot_white = (s1_bot_ff == PIX_WHITE);

   txo_window u_window (
      .clock     (clock),
      .reset     (reset),
      .advance   (s1_adv),
      .pos       (s1_pos_ff),
      .top_white (top_white),
      .mid_pix   (mid_pix),
      .bot_white (bot_white),
      .result    (result)
   );

   // ------------------------------------------------------------------- output
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv && s1_pos_ff.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_pos_ff.emit) begin
         rsp_data_ff <= result;
         rsp_last_ff <= s1_pos_ff.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: design/txo_position.sv
// Raster position tracking of the outline filter: column, row and result counters.
// Depends on txo_pkg.
module txo_position #(
   parameter int MAX_WIDTH = txo_pkg::DEF_MAX_WIDTH,
   parameter int CW        = $clog2(MAX_WIDTH + 1),
   parameter int IW        = $clog2(MAX_WIDTH),
   parameter int PW        = CW + txo_pkg::CFG_HEIGHT_W
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic [CW-1:0]                      eff_width,
   input  logic [txo_pkg::CFG_HEIGHT_W-1:0]   eff_height,
   input  logic [PW-1:0]                      pixel_limit,
   output logic [IW-1:0]                      line_idx,
   output txo_pkg::pos_type                   pos
);
   import txo_pkg::*;

   localparam int CMPW = (PW > EMIT_W) ? PW : EMIT_W;

   logic [CW-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [EMIT_W-1:0] emit_cnt_ff, emit_cnt_in;

   logic [CW-1:0]    col_a, col_b;
   logic [ROW_W-1:0] row_a, row_b;

   function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] r);
      row_inc = (r == ROW_MAX) ? r : r + ROW_W'(1);
   endfunction

   always_comb begin
      // A column count left beyond a narrowed width starts a new row.
      if (col_ff >= eff_width) begin
         col_a = '0;
         row_a = row_inc(row_ff);
      end else begin
         col_a = col_ff;
         row_a = row_ff;
      end
      line_idx = col_a[IW-1:0];

      pos.in_rows = row_a < eff_height;
      pos.mid_en  = (row_a != '0) && (row_a <= eff_height);
      pos.top_en  = (row_a >= ROW_W'(2)) &&
                    ({1'b0, row_a} < ({1'b0, eff_height} + (ROW_W + 1)'(2)));
      pos.col0    = (col_a == '0);
      pos.emit    = pos.col0 ? (row_a >= ROW_W'(2)) : (row_a != '0);
      pos.last    = pos.emit && (CMPW'(emit_cnt_ff) >= CMPW'(pixel_limit));

      col_b = col_a + CW'(1);
      row_b = row_a;
      if (col_b >= eff_width) begin
         col_b = '0;
         row_b = row_inc(row_a);
      end

      col_in      = col_ff;
      row_in      = row_ff;
      emit_cnt_in = emit_cnt_ff;
      if (accept) begin
         if (pos.last) begin
            col_in      = '0;
            row_in      = '0;
            emit_cnt_in = '0;
         end else begin
            col_in = col_b;
            row_in = row_b;
            if (pos.emit) begin
               emit_cnt_in = emit_cnt_ff + EMIT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         emit_cnt_ff <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         emit_cnt_ff <= emit_cnt_in;
      end
   end

endmodule

// File: design/txo_window.sv
// 3x3 window registers of the outline filter and the outline decision on them.
// Depends on txo_pkg.
module txo_window (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  txo_pkg::pos_type            pos,
   input  logic                        top_white,
   input  logic [txo_pkg::PIX_W-1:0]   mid_pix,
   input  logic                        bot_white,
   output logic [txo_pkg::PIX_W-1:0]   result
);
   import txo_pkg::*;

   // Column 0 holds the newest pixel. The outer rows only ever matter as
   // "is white", so they keep one flag per column.
   logic [2:0]            top_ff, top_in;
   logic [2:0]            bot_ff, bot_in;
   logic [2:0][PIX_W-1:0] mid_ff, mid_in;

   logic [2:0]            top_v, bot_v;
   logic [2:0][PIX_W-1:0] mid_v;
   logic                  hit;

   always_comb begin
      if (pos.col0) begin
         // The first column closes the previous row: its window is shifted
         // with an outside column, and the new column starts a fresh window.
         top_v  = {top_ff[1:0], 1'b0};
         bot_v  = {bot_ff[1:0], 1'b0};
         mid_v  = {mid_ff[1], mid_ff[0], PIX_ZERO};
         top_in = {2'b00, top_white};
         bot_in = {2'b00, bot_white};
         mid_in = {PIX_ZERO, PIX_ZERO, mid_pix};
      end else begin
         top_v  = {top_ff[1:0], top_white};
         bot_v  = {bot_ff[1:0], bot_white};
         mid_v  = {mid_ff[1], mid_ff[0], mid_pix};
         top_in = top_v;
         bot_in = bot_v;
         mid_in = mid_v;
      end
      if (pos.last) begin
         top_in = '0;
         bot_in = '0;
         mid_in = '0;
      end

      hit    = (|top_v) || (|bot_v) || (mid_v[0] == PIX_WHITE) || (mid_v[2] == PIX_WHITE);
      result = (mid_v[1] != PIX_ZERO) ? mid_v[1] : PIX_W'(hit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= '0;
         bot_ff <= '0;
         mid_ff <= '0;
      end else if (advance) begin
         top_ff <= top_in;
         bot_ff <= bot_in;
         mid_ff <= mid_in;
      end
   end

endmodule

// File: test/text_outline_3x3_checker.sv
// Scoreboard for the 3x3 text outline filter: watches the pixel, result and register ports,
// predicts every outlined pixel and compares it with what the block returns.
// Depends on txo_pkg.
module text_outline_3x3_checker #(
   parameter int MAX_WIDTH = txo_pkg::DEF_MAX_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [txo_pkg::PIX_W-1:0]        req_tdata,   // [7:0] pixel_in
   input  logic                             req_tuser,   // [0] flush

   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [txo_pkg::PIX_W-1:0]        rsp_tdata,   // [7:0] pixel_out
   input  logic                             rsp_tlast,   // frame_last

   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [txo_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [txo_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input  logic                             csr_pready,

   output int                               mismatch_count,
   output int                               pending_results,
   output logic                             frame_idle
);
   timeunit 1ns;
   timeprecision 1ps;

   import txo_pkg::*;

   localparam int MAX_PRINTED = 60;
   localparam int EMIT_MOD    = 1 << EMIT_W;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             last;
   } outline_pixel_type;

   outline_pixel_type        expected_pixels[$];

   logic [CFG_WIDTH_W-1:0]   width_reg;
   logic [CFG_HEIGHT_W-1:0]  height_reg;
   logic [PIX_W-1:0]         line_pixels [MAX_WIDTH];
   logic                     white_flags [MAX_WIDTH];
   logic [3*PIX_W-1:0]       win_above;
   logic [3*PIX_W-1:0]       win_center;
   logic [3*PIX_W-1:0]       win_below;
   int                       col_pos;
   int                       row_pos;
   int                       emitted;
   int                       results_seen;

   function automatic int clamped_width(input logic [CFG_WIDTH_W-1:0] value);
      if (value < WIDTH_MIN) return WIDTH_MIN;
      if (value > MAX_WIDTH) return MAX_WIDTH;
      return int'(value);
   endfunction

   function automatic int clamped_height(input logic [CFG_HEIGHT_W-1:0] value);
      if (value < HEIGHT_MIN) return int'(HEIGHT_MIN);
      if (value > HEIGHT_MAX) return int'(HEIGHT_MAX);
      return int'(value);
   endfunction

   function automatic logic is_white(input logic [PIX_W-1:0] value);
      return value == PIX_WHITE;
   endfunction

   // The center pixel sits in the middle byte of the middle row.
   function automatic logic [PIX_W-1:0] outline_pixel(input logic [3*PIX_W-1:0] above,
                                                      input logic [3*PIX_W-1:0] center,
                                                      input logic [3*PIX_W-1:0] below);
      logic hit;
      if (center[15:8] != PIX_ZERO) return center[15:8];
      hit = is_white(above[7:0]) || is_white(above[15:8]) || is_white(above[23:16]) ||
            is_white(center[7:0]) || is_white(center[23:16]) ||
            is_white(below[7:0]) || is_white(below[15:8]) || is_white(below[23:16]);
      return hit ? 8'd1 : PIX_ZERO;
   endfunction

   task automatic clear_model();
      width_reg  = RST_WIDTH;
      height_reg = RST_HEIGHT;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         line_pixels[i] = PIX_ZERO;
         white_flags[i] = 1'b0;
      end
      win_above  = '0;
      win_center = '0;
      win_below  = '0;
      col_pos    = 0;
      row_pos    = 0;
      emitted    = 0;
   endtask

   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_PRINTED) $display("%0t: mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic predict_pixel(input logic [PIX_W-1:0] pix, input logic flush);
      int             w;
      int             h;
      int             c;
      int             r;
      int             idx;
      logic [PIX_W-1:0] above;
      logic [PIX_W-1:0] center;
      logic [PIX_W-1:0] below;
      logic [PIX_W-1:0] value;
      logic           makes_result;
      outline_pixel_type item;
      w = clamped_width(width_reg);
      h = clamped_height(height_reg);
      c = col_pos;
      r = row_pos;
      // A column count left beyond a narrowed width wraps to a new row first.
      if (c >= w) begin
         c = 0;
         if (r < int'(ROW_MAX)) r++;
      end
      idx = c % MAX_WIDTH;

      below  = (flush || r >= h) ? PIX_ZERO : pix;
      above  = (r >= 2 && r - 2 < h && white_flags[idx]) ? PIX_WHITE : PIX_ZERO;
      center = (r >= 1 && r - 1 < h) ? line_pixels[idx] : PIX_ZERO;
      white_flags[idx] = is_white(center);
      line_pixels[idx] = below;

      if (c == 0) begin
         // The first column finishes the last pixel of the previous row, with the
         // right-hand neighbors outside the frame.
         value = outline_pixel({win_above[15:0], PIX_ZERO}, {win_center[15:0], PIX_ZERO},
                               {win_below[15:0], PIX_ZERO});
         makes_result = r >= 2;
         win_above  = {16'h0, above};
         win_center = {16'h0, center};
         win_below  = {16'h0, below};
      end else begin
         win_above  = {win_above[15:0], above};
         win_center = {win_center[15:0], center};
         win_below  = {win_below[15:0], below};
         makes_result = r >= 1;
         value = outline_pixel(win_above, win_center, win_below);
      end

      c++;
      if (c >= w) begin
         c = 0;
         if (r < int'(ROW_MAX)) r++;
      end
      col_pos = c;
      row_pos = r;

      if (makes_result) begin
         item.pixel = value;
         item.last  = 1'b0;
         if (emitted >= w * h - 1) begin
            item.last  = 1'b1;
            emitted    = 0;
            col_pos    = 0;
            row_pos    = 0;
            win_above  = '0;
            win_center = '0;
            win_below  = '0;
         end else begin
            emitted = (emitted + 1) % EMIT_MOD;
         end
         expected_pixels.push_back(item);
      end
   endtask

   task automatic check_result();
      outline_pixel_type want;
      results_seen++;
      if (expected_pixels.size() == 0) begin
         report_mismatch($sformatf("result %0d: pixel %0d last %0b with nothing expected",
                                   results_seen, rsp_tdata, rsp_tlast));
         return;
      end
      want = expected_pixels.pop_front();
      if (rsp_tdata !== want.pixel)
         report_mismatch($sformatf("result %0d: pixel %0d, expected %0d",
                                   results_seen, rsp_tdata, want.pixel));
      if (rsp_tlast !== want.last)
         report_mismatch($sformatf("result %0d: frame end flag %0b, expected %0b",
                                   results_seen, rsp_tlast, want.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_model();
         expected_pixels.delete();
         mismatch_count = 0;
         results_seen   = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_FRAME_WIDTH) width_reg = csr_pwdata[CFG_WIDTH_W-1:0];
            else height_reg = csr_pwdata[CFG_HEIGHT_W-1:0];
         end
         if (req_tvalid && req_tready) predict_pixel(req_tdata, req_tuser);
      end
      pending_results <= expected_pixels.size();
      frame_idle      <= (col_pos == 0 && row_pos == 0 && emitted == 0);
   end

endmodule

// File: test/text_outline_3x3_core_test.sv
// Testbench top for text_outline_3x3_core: drives frames of pixels, drain items and
// register writes under several idling patterns, and prints the verdict.
// Depends on txo_pkg, the core and text_outline_3x3_checker.
module text_outline_3x3_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import txo_pkg::*;

   localparam int CLOCK_PERIOD  = 10;
   localparam int RESET_CYCLES  = 9;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_ITEMS  = 1350;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [PIX_W-1:0]        req_tdata   = '0;
   logic                    req_tuser   = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic [PIX_W-1:0]        rsp_tdata;
   logic                    rsp_tlast;
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   int                      mismatch_count;
   int                      pending_results;
   logic                    frame_idle;

   int                      src_idle_pct   = 0;
   int                      sink_stall_pct = 0;
   int                      cycle_count    = 0;
   int                      eff_w;
   int                      eff_h;

   text_outline_3x3_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   text_outline_3x3_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results),
      .frame_idle      (frame_idle)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic logic [PIX_W-1:0] random_pixel();
      int pick;
      pick = $urandom_range(99);
      if (pick < 40) return PIX_ZERO;
      if (pick < 70) return PIX_WHITE;
      if (pick < 78) return 8'd1;
      return PIX_W'($urandom_range(255));
   endfunction

   task automatic set_idling(input int src_pct, input int sink_pct);
      src_idle_pct   = src_pct;
      sink_stall_pct <= sink_pct;
   endtask

   // One transaction on the pixel channel; valid stays high on return.
   task automatic push_item(input logic [PIX_W-1:0] pix, input logic flush);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tuser  <= flush;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Items that make no result may still be inside the block, hence the extra cycles.
   task automatic finish_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic index, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_height(input int height_value);
      write_reg(REG_FRAME_HEIGHT, CSR_DATA_W'(height_value));
      eff_h = height_value < 1 ? 1 : (height_value > 4096 ? 4096 : height_value);
   endtask

   task automatic configure(input int width_value, input int height_value);
      write_reg(REG_FRAME_WIDTH, CSR_DATA_W'(width_value));
      eff_w = width_value < WIDTH_MIN ? WIDTH_MIN :
              (width_value > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : width_value);
      write_height(height_value);
   endtask

   // Drain items: mostly flush transactions, some plain pixels past the frame end.
   task automatic push_drain();
      if ($urandom_range(4) == 0) push_item(random_pixel(), 1'b0);
      else push_item(PIX_W'($urandom), 1'b1);
   endtask

   task automatic send_frame(output int sent);
      sent = 0;
      for (int i = 0; i < eff_w * eff_h; i++) begin
         if ($urandom_range(99) < 3) push_item(PIX_W'($urandom), 1'b1);
         else push_item(random_pixel(), 1'b0);
         sent++;
      end
      for (int i = 0; i <= eff_w; i++) begin
         push_drain();
         sent++;
      end
      finish_idle();
   endtask

   // Stops a frame part way, lowers the height and sends drain items until the
   // frame has closed.
   task automatic cut_frame(input int count, input int new_height, output int sent);
      sent = 0;
      for (int i = 0; i < count; i++) begin
         push_item(random_pixel(), 1'b0);
         sent++;
      end
      finish_idle();
      write_height(new_height);
      do begin
         push_item(PIX_W'($urandom), 1'b1);
         req_tvalid <= 1'b0;
         @(posedge clock);
         sent++;
      end while (!frame_idle);
      finish_idle();
   endtask

   task automatic run_directed();
      logic [PIX_W-1:0] pixels [12];
      logic             flushes [12];
      int               sent;
      // White corner pixel, isolated values that must pass unchanged, and a
      // flush inside the frame carrying a white value that must not count.
      pixels  = '{PIX_WHITE, PIX_ZERO, PIX_ZERO, 8'd7,
                  PIX_ZERO,  PIX_ZERO, 8'd254,   PIX_ZERO,
                  8'd1,      PIX_ZERO, PIX_WHITE, PIX_ZERO};
      flushes = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
      configure(4, 3);
      for (int i = 0; i < 12; i++) push_item(pixels[i], flushes[i]);
      push_item(PIX_WHITE, 1'b0);
      for (int i = 0; i < 4; i++) push_item(PIX_W'($urandom), 1'b1);
      finish_idle();

      configure(3, 4);
      push_item(PIX_WHITE, 1'b0);
      push_item(PIX_ZERO, 1'b0);
      push_item(PIX_ZERO, 1'b0);
      push_item(PIX_ZERO, 1'b0);
      cut_frame(1, 1, sent);
   endtask

   initial begin
      int random_sent;
      int frame_no;
      int sent;
      int width_value;
      int height_value;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      random_sent = 0;
      frame_no    = 0;
      while (random_sent < RANDOM_ITEMS) begin
         case (frame_no % 4)
            0: set_idling(0, 0);
            1: set_idling(58, 0);
            2: set_idling(0, 58);
            default: set_idling(10, 10);
         endcase
         if (frame_no == 3) begin
            // An oversized height saturates; the frame is closed early by a lower one.
            configure(3, 8191);
            cut_frame($urandom_range(1, 40), $urandom_range(1, 4), sent);
         end else if (frame_no == 9) begin
            configure(1, 0);
            send_frame(sent);
         end else begin
            width_value  = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 12);
            height_value = ($urandom_range(11) == 0) ? 0 : $urandom_range(1, 8);
            configure(width_value, height_value);
            if (eff_h >= 2 && $urandom_range(7) == 0)
               cut_frame($urandom_range(1, eff_w * eff_h - 1), $urandom_range(eff_h - 1), sent);
            else
               send_frame(sent);
         end
         random_sent += sent;
         frame_no++;
      end

      set_idling(0, 0);
      finish_idle();
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
